@@ hw/rtl/upload_generation_stamp_table_assert.svh @@
// assertion macros for the upload generation stamp table checker
// used by ugst_checker; no other dependencies
`ifndef UPLOAD_GENERATION_STAMP_TABLE_ASSERT_SVH
`define UPLOAD_GENERATION_STAMP_TABLE_ASSERT_SVH

// same-cycle implication
`define UGST_ASSERT_IMPLY(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("upload_generation_stamp_table: same-cycle check failed");

// next-cycle implication
`define UGST_ASSERT_NEXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("upload_generation_stamp_table: next-cycle check failed");

`endif

@@ hw/rtl/ugst_pkg.sv @@
// shared types, constants and stamp functions for the generation stamp table
// no dependencies
package ugst_pkg;

  localparam int unsigned DOMAIN_COUNT_DEF = 8;
  localparam int unsigned DOMAIN_W         = 4;
  localparam int unsigned KEY_W            = 64;
  localparam int unsigned STAMP_W          = 64;
  localparam int unsigned STAMP_CNT        = 5;
  localparam int unsigned IN_FIELDS_W      = DOMAIN_W + 2 * KEY_W + 2;
  localparam int unsigned IN_TDATA_W       = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W      = STAMP_CNT * STAMP_W;

  localparam logic [STAMP_W-1:0] STAMP_SEED   = 64'd1469598103934665603;
  localparam logic [STAMP_W-1:0] STAMP_GOLDEN = 64'h9e3779b97f4a7c15;

  localparam logic [STAMP_W-1:0] CH_VERTEX     = 64'd1;
  localparam logic [STAMP_W-1:0] CH_INDEX      = 64'd2;
  localparam logic [STAMP_W-1:0] CH_PRIMITIVE  = 64'd3;
  localparam logic [STAMP_W-1:0] CH_PROVENANCE = 64'd4;
  localparam logic [STAMP_W-1:0] CH_MATERIAL   = 64'd5;

  typedef struct packed {
    logic                force_layout_change;
    logic                force_content_change;
    logic [KEY_W-1:0]    layout_key;
    logic [KEY_W-1:0]    content_key;
    logic [DOMAIN_W-1:0] domain_index;
  } ugst_req_t;

  typedef struct packed {
    logic               accepted;
    logic [KEY_W-1:0]   content_gen;
    logic [KEY_W-1:0]   layout_gen;
  } ugst_gen_t;

  function automatic logic [STAMP_W-1:0] mix_step(input logic [STAMP_W-1:0] h,
                                                 input logic [STAMP_W-1:0] v);
    return h ^ (v + STAMP_GOLDEN + (h << 6) + (h >> 2));
  endfunction

  function automatic logic [KEY_W-1:0] advance_gen(input logic [KEY_W-1:0] g);
    logic [KEY_W-1:0] inc;
    inc = g + 64'd1;
    return (inc != '0) ? inc : 64'd1;
  endfunction

  function automatic logic [STAMP_W-1:0] fix_zero(input logic [STAMP_W-1:0] h);
    return (h != '0) ? h : 64'd1;
  endfunction

endpackage

@@ hw/rtl/ugst_table.sv @@
// per-domain record table: valid bits, last keys, generation counters
// computes the next generations for the request in the input register; uses ugst_pkg
module ugst_table
  import ugst_pkg::*;
#(
  parameter int unsigned DOMAIN_COUNT = DOMAIN_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  ugst_req_t req,
  input  logic      req_fire,
  output ugst_gen_t gen
);

  localparam int unsigned IDX_W = (DOMAIN_COUNT > 1) ? $clog2(DOMAIN_COUNT) : 1;
  localparam int unsigned CNT_W = DOMAIN_W + 1;

  logic             valid_r [DOMAIN_COUNT];
  logic [KEY_W-1:0] ckey_r  [DOMAIN_COUNT];
  logic [KEY_W-1:0] lkey_r  [DOMAIN_COUNT];
  logic [KEY_W-1:0] cgen_r  [DOMAIN_COUNT];
  logic [KEY_W-1:0] lgen_r  [DOMAIN_COUNT];

  logic             in_range;
  logic [IDX_W-1:0] rd_idx;
  logic             ent_valid;
  logic [KEY_W-1:0] cur_cg;
  logic [KEY_W-1:0] cur_lg;
  logic             c_chg;
  logic             l_chg;
  logic [KEY_W-1:0] cgen_nxt;
  logic [KEY_W-1:0] lgen_nxt;

  always_comb begin
    in_range  = ({1'b0, req.domain_index} < CNT_W'(DOMAIN_COUNT));
    rd_idx    = in_range ? req.domain_index[IDX_W-1:0] : '0;
    ent_valid = valid_r[rd_idx];
    cur_cg    = ent_valid ? cgen_r[rd_idx] : '0;
    cur_lg    = ent_valid ? lgen_r[rd_idx] : '0;
    c_chg     = req.force_content_change || !ent_valid || (req.content_key == '0) ||
                (ckey_r[rd_idx] != req.content_key);
    l_chg     = req.force_layout_change || !ent_valid || (req.layout_key == '0) ||
                (lkey_r[rd_idx] != req.layout_key);
    cgen_nxt  = c_chg ? advance_gen(cur_cg) : cur_cg;
    lgen_nxt  = l_chg ? advance_gen(cur_lg) : cur_lg;
    gen.accepted    = in_range;
    gen.content_gen = cgen_nxt;
    gen.layout_gen  = lgen_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DOMAIN_COUNT; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else if (req_fire && in_range) begin
      valid_r[rd_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire && in_range) begin
      ckey_r[rd_idx] <= req.content_key;
      lkey_r[rd_idx] <= req.layout_key;
      cgen_r[rd_idx] <= cgen_nxt;
      lgen_r[rd_idx] <= lgen_nxt;
    end
  end

endmodule

@@ hw/rtl/ugst_stamp.sv @@
// stamp pipeline: an input register, then three combine steps, one per stage, the last into the output register
// uses ugst_pkg
module ugst_stamp
  import ugst_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  ugst_gen_t              s_gen,
  input  logic                   s_valid,
  output logic                   s_ready,
  output logic                   m_valid,
  input  logic                   m_ready,
  output logic [OUT_TDATA_W-1:0] m_stamps,
  output logic                   m_accepted
);

  logic                   v1_r, v2_r, v3_r, vo_r;
  logic                   rdy1, rdy2, rdy3, rdy_o;
  ugst_gen_t              gen1_r;
  logic                   acc2_r, acc3_r, acco_r;
  logic [STAMP_W-1:0]     hc2_r, hl2_r, lg2_r;
  logic [STAMP_W-1:0]     ha3_r, hb3_r;
  logic [STAMP_W-1:0]     hc2_nxt, hl2_nxt;
  logic [STAMP_W-1:0]     ha3_nxt, hb3_nxt;
  logic [OUT_TDATA_W-1:0] stamps_r;
  logic [OUT_TDATA_W-1:0] stamps_nxt;

  assign rdy_o   = !vo_r || m_ready;
  assign rdy3    = !v3_r || rdy_o;
  assign rdy2    = !v2_r || rdy3;
  assign rdy1    = !v1_r || rdy2;
  assign s_ready = rdy1;

  always_comb begin
    hc2_nxt = mix_step(STAMP_SEED, gen1_r.content_gen);
    hl2_nxt = mix_step(STAMP_SEED, gen1_r.layout_gen);
    ha3_nxt = mix_step(hc2_r, lg2_r);
    hb3_nxt = mix_step(hl2_r, lg2_r);
    if (acc3_r) begin
      stamps_nxt = {fix_zero(mix_step(ha3_r, CH_MATERIAL)),
                    fix_zero(mix_step(hb3_r, CH_PROVENANCE)),
                    fix_zero(mix_step(ha3_r, CH_PRIMITIVE)),
                    fix_zero(mix_step(hb3_r, CH_INDEX)),
                    fix_zero(mix_step(ha3_r, CH_VERTEX))};
    end else begin
      stamps_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= s_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy_o) vo_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && s_valid) begin
      gen1_r <= s_gen;
    end
    if (rdy2 && v1_r) begin
      acc2_r <= gen1_r.accepted;
      hc2_r  <= hc2_nxt;
      hl2_r  <= hl2_nxt;
      lg2_r  <= gen1_r.layout_gen;
    end
    if (rdy3 && v2_r) begin
      acc3_r <= acc2_r;
      ha3_r  <= ha3_nxt;
      hb3_r  <= hb3_nxt;
    end
    if (rdy_o && v3_r) begin
      acco_r   <= acc3_r;
      stamps_r <= stamps_nxt;
    end
  end

  assign m_valid    = vo_r;
  assign m_stamps   = stamps_r;
  assign m_accepted = acco_r;

endmodule

@@ hw/rtl/upload_generation_stamp_table.sv @@
// top level of the upload generation stamp table: input register and stream ports
// instantiates ugst_table and ugst_stamp; uses ugst_pkg
//
// Each request publishes new content and layout generations for one domain and
// returns five 64-bit channel stamps. One request can be taken every clock cycle
// as long as the output is not stalled; the limit is the read-modify-write of the
// register-held record table. A result passes from the input register through
// the stamp stages to the output in request order, and the block keeps taking
// requests while a result waits as long as a pipeline stage is free. A domain at
// or above DOMAIN_COUNT returns out_tuser low and all-zero stamps and leaves the
// table untouched. Reset clears every record; there is no other clear.
module upload_generation_stamp_table
  import ugst_pkg::*;
#(
  parameter int unsigned DOMAIN_COUNT = DOMAIN_COUNT_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // domain_index[3:0], content_key, layout_key, force_content_change,
  // force_layout_change, zero fill
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // vertex_stamp, index_stamp, primitive_stamp, provenance_stamp, material_stamp
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // domain_accepted
  output logic                   out_tuser
);

  logic      in_v_r;
  ugst_req_t req_r;
  logic      stamp_ready;
  logic      req_fire;
  ugst_gen_t gen;

  assign req_fire  = in_v_r && stamp_ready;
  assign in_tready = !in_v_r || stamp_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      req_r <= ugst_req_t'(in_tdata[IN_FIELDS_W-1:0]);
    end
  end

  ugst_table #(
    .DOMAIN_COUNT(DOMAIN_COUNT)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req_r),
    .req_fire (req_fire),
    .gen      (gen)
  );

  ugst_stamp u_stamp (
    .clk        (clk),
    .rst_n      (rst_n),
    .s_gen      (gen),
    .s_valid    (in_v_r),
    .s_ready    (stamp_ready),
    .m_valid    (out_tvalid),
    .m_ready    (out_tready),
    .m_stamps   (out_tdata),
    .m_accepted (out_tuser)
  );

endmodule

@@ hw/rtl/ugst_checker.sv @@
// port-level checks for the upload generation stamp table, bound to the top level
// uses ugst_pkg and upload_generation_stamp_table_assert.svh
`include "upload_generation_stamp_table_assert.svh"

module ugst_checker
  import ugst_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_TDATA_W-1:0]  in_tdata,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser
);

  // waiting request holds
  `UGST_ASSERT_NEXT(a_in_hold, clk, rst_n, in_tvalid && !in_tready, in_tvalid && $stable(in_tdata))

  // stalled result holds
  `UGST_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // rejected domain gives zero stamps
  `UGST_ASSERT_IMPLY(a_reject_zero, clk, rst_n, out_tvalid && !out_tuser, out_tdata == '0)

  // accepted domain never gives a zero stamp
  `UGST_ASSERT_IMPLY(a_accept_nonzero, clk, rst_n, out_tvalid && out_tuser, (out_tdata[63:0] != '0) && (out_tdata[127:64] != '0) && (out_tdata[191:128] != '0) && (out_tdata[255:192] != '0) && (out_tdata[319:256] != '0))

  // empty output means the pipeline can take a request
  `UGST_ASSERT_IMPLY(a_ready_when_empty, clk, rst_n, !out_tvalid, in_tready)

endmodule

bind upload_generation_stamp_table ugst_checker u_ugst_checker (.*);
